>>> rtl/srof_pkg.sv
// ----------------------------------------------------------------------------
// srof_pkg
// Shared types and constants of the SNTP reply offset filter.
// ----------------------------------------------------------------------------
package srof_pkg;

  // Action codes of an input item
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_MISS  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Reject reasons, first failing check wins
  typedef enum logic [2:0] {
    RS_NONE     = 3'd0,
    RS_LENGTH   = 3'd1,
    RS_COOKIE   = 3'd2,
    RS_VERSION  = 3'd3,
    RS_MODE     = 3'd4,
    RS_STRATUM  = 3'd5,
    RS_ZERO_TX  = 3'd6,
    RS_NO_REPLY = 3'd7
  } reason_e;

  typedef enum logic [2:0] {
    VD_STARTED      = 3'd0,
    VD_ACCEPTED     = 3'd1,
    VD_REJECTED     = 3'd2,
    VD_FAIL_REJECTS = 3'd3,
    VD_FAIL_INCONS  = 3'd4,
    VD_GOAL_MET     = 3'd5,
    VD_LIMIT        = 3'd6,
    VD_IGNORED      = 3'd7
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_MAX_QUERIES   = 2'd0,
    CFG_ERROR_GOAL    = 2'd1,
    CFG_INITIAL_ERROR = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [7:0]  MIN_LEN     = 8'd48;
  localparam logic [7:0]  MAX_LEN     = 8'd68;
  localparam logic [7:0]  MAX_STRATUM = 8'd14;
  localparam logic [2:0]  SERVER_MODE = 3'd4;
  localparam logic [2:0]  MIN_VERSION = 3'd1;
  localparam logic [2:0]  MAX_VERSION = 3'd4;
  localparam logic [1:0]  LEAP_ALARM  = 2'd3;

  localparam logic [7:0]  MAX_QUERIES_RST   = 8'd25;
  localparam logic [39:0] ERROR_GOAL_RST    = 40'd429496730;
  localparam logic [47:0] INITIAL_ERROR_RST = 48'd15461882265600;

  localparam logic [63:0] OFFSET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] OFFSET_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  packet_length;
    logic [7:0]  header_byte;
    logic [7:0]  stratum;
    logic [63:0] echoed_cookie;
    logic [63:0] sent_cookie;
    logic [63:0] server_receive_time;
    logic [63:0] server_transmit_time;
    logic [63:0] local_send_time;
    logic [63:0] local_arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic [2:0]         reject_reason;
    logic signed [63:0] sample_offset;
    logic [63:0]        sample_error;
    logic signed [63:0] best_offset_out;
    logic [63:0]        best_error_out;
    logic [7:0]         accepted_out;
    logic               alarm_first;
  } out_item_t;

  // Classified item handed from the front end to the session back end
  typedef struct packed {
    action_e     action;
    reason_e     reason;
    logic        leap_alarm;
    logic [63:0] sample_offset;
    logic [63:0] sample_error;
  } work_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

>>> rtl/sntp_reply_offset_filter.sv
// ----------------------------------------------------------------------------
// sntp_reply_offset_filter
// SNTP reply checker and clock offset filter with best-estimate tracking.
// ----------------------------------------------------------------------------
// Push one item per session event (start, reply, no reply) and pop one result
// per item, in order. A front pipeline of three register stages checks the
// reply header and computes the sample offset ((T2-T1)+(T3-T4))/2 and error
// max(|(T2-T1)-(T3-T4)|, |T4-T1|/2) in 32.32 fixed point; it takes a new item
// every cycle unless the queue behind it is full. A queue of MID_DEPTH
// entries decouples it from the session back end, which compares each
// sample to the stored best estimate and commits the session state in an
// evaluate state followed by a commit state. The back end takes no new item
// until it has committed the previous one, because of the read-modify-write
// of the best estimate. Results wait in a queue of OUT_DEPTH entries, so the
// input side keeps accepting while the consumer stalls, until both queues
// fill. The configuration channel is always ready; write it only while no
// item is in flight.
module sntp_reply_offset_filter #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input queue side
  input  srof_pkg::in_item_t                in_item_i,
  input  logic                              push,
  output logic                              full,
  // result queue side
  output srof_pkg::out_item_t               out_item_o,
  output logic                              empty,
  input  logic                              pop,
  // configuration write channel
  input  logic                              valid,
  output logic                              ready,
  input  logic [srof_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [srof_pkg::CfgDataW-1:0]     cfg_data_i
);
  import srof_pkg::*;

  work_t     fe_work, be_work;
  logic      fe_push, mid_full, mid_empty, be_pop;
  out_item_t be_res;
  logic      res_push, res_full;
  cfg_wr_t   cfg_wr;

  // Config writes go straight into registers, so never hold the channel off.
  assign ready = 1'b1;

  always_comb begin
    cfg_wr.valid = valid && ready;
    cfg_wr.index = cfg_index_i;
    cfg_wr.data  = cfg_data_i;
  end

  srof_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item_i),
    .push_i      (push),
    .full_o      (full),
    .work_o      (fe_work),
    .work_push_o (fe_push),
    .work_full_i (mid_full)
  );

  // Classified items between front and back end
  srof_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_work),
    .full_o  (mid_full),
    .pop_i   (be_pop),
    .rdata_o (be_work),
    .empty_o (mid_empty)
  );

  srof_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .work_i       (be_work),
    .work_empty_i (mid_empty),
    .work_pop_o   (be_pop),
    .res_o        (be_res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  // Finished results; the head entry drives the result ports
  srof_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (be_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

>>> rtl/srof_fifo.sv
// ----------------------------------------------------------------------------
// srof_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module srof_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push without pop did not grow the queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with count");

endmodule

>>> rtl/srof_front.sv
// ----------------------------------------------------------------------------
// srof_front
// Accept items, run the reply checks and compute the sample offset and
// error bound in a three-stage pipeline.
// ----------------------------------------------------------------------------
module srof_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srof_pkg::in_item_t item_i,
  input  logic              push_i,
  output logic              full_o,
  output srof_pkg::work_t   work_o,
  output logic              work_push_o,
  input  logic              work_full_i
);
  import srof_pkg::*;

  logic        adv, accept;
  reason_e     rsn_d;
  logic [2:0]  ver;

  // stage 1: partial sums
  logic        v1_q;
  action_e     act1_q;
  reason_e     rsn1_q;
  logic        leap1_q;
  logic [64:0] s1_q, s2_q, e1_q, e2_q, dt1_q;

  // stage 2: full differences
  logic        v2_q;
  action_e     act2_q;
  reason_e     rsn2_q;
  logic        leap2_q;
  logic [65:0] doff2_q, derr2_q;
  logic [63:0] hdt2_q;
  logic [64:0] absdt;

  // stage 3: rounded and saturated
  logic        v3_q;
  action_e     act3_q;
  reason_e     rsn3_q;
  logic        leap3_q;
  logic [63:0] off3_q, aerr3_q, hdt3_q;
  logic [64:0] half_off;
  logic [63:0] off_sat;
  logic [65:0] aabs;
  logic [63:0] aerr_sat;

  assign adv    = !v3_q || !work_full_i;
  assign full_o = !adv;
  assign accept = push_i && adv;
  assign ver    = item_i.header_byte[5:3];

  always_comb begin
    if (action_e'(item_i.action) == ACT_MISS) begin
      rsn_d = RS_NO_REPLY;
    end else if (!(item_i.packet_length inside {[MIN_LEN:MAX_LEN]})) begin
      rsn_d = RS_LENGTH;
    end else if (item_i.echoed_cookie != item_i.sent_cookie) begin
      rsn_d = RS_COOKIE;
    end else if (!(ver inside {[MIN_VERSION:MAX_VERSION]})) begin
      rsn_d = RS_VERSION;
    end else if (item_i.header_byte[2:0] != SERVER_MODE) begin
      rsn_d = RS_MODE;
    end else if (item_i.stratum > MAX_STRATUM) begin
      rsn_d = RS_STRATUM;
    end else if (item_i.server_transmit_time == '0) begin
      rsn_d = RS_ZERO_TX;
    end else begin
      rsn_d = RS_NONE;
    end
  end

  assign absdt = dt1_q[64] ? (65'd0 - dt1_q) : dt1_q;

  always_comb begin
    // floor halving keeps the sign bit
    half_off = doff2_q[65:1];
    if (half_off[64] == half_off[63]) begin
      off_sat = half_off[63:0];
    end else if (!half_off[64]) begin
      off_sat = OFFSET_MAX;
    end else begin
      off_sat = OFFSET_MIN;
    end
    aabs     = derr2_q[65] ? (66'd0 - derr2_q) : derr2_q;
    aerr_sat = (aabs[65:64] != 2'b00) ? '1 : aabs[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act1_q  <= action_e'(item_i.action);
      rsn1_q  <= rsn_d;
      leap1_q <= (item_i.header_byte[7:6] == LEAP_ALARM);
      s1_q    <= {1'b0, item_i.server_receive_time} + {1'b0, item_i.server_transmit_time};
      s2_q    <= {1'b0, item_i.local_send_time} + {1'b0, item_i.local_arrival_time};
      e1_q    <= {1'b0, item_i.server_receive_time} + {1'b0, item_i.local_arrival_time};
      e2_q    <= {1'b0, item_i.local_send_time} + {1'b0, item_i.server_transmit_time};
      dt1_q   <= {1'b0, item_i.local_arrival_time} - {1'b0, item_i.local_send_time};

      act2_q  <= act1_q;
      rsn2_q  <= rsn1_q;
      leap2_q <= leap1_q;
      doff2_q <= {1'b0, s1_q} - {1'b0, s2_q};
      derr2_q <= {1'b0, e1_q} - {1'b0, e2_q};
      hdt2_q  <= absdt[64:1];

      act3_q  <= act2_q;
      rsn3_q  <= rsn2_q;
      leap3_q <= leap2_q;
      off3_q  <= off_sat;
      aerr3_q <= aerr_sat;
      hdt3_q  <= hdt2_q;
    end
  end

  always_comb begin
    work_o.action        = act3_q;
    work_o.reason        = rsn3_q;
    work_o.leap_alarm    = leap3_q;
    work_o.sample_offset = off3_q;
    work_o.sample_error  = (hdt3_q > aerr3_q) ? hdt3_q : aerr3_q;
  end

  assign work_push_o = v3_q && !work_full_i;

endmodule

>>> rtl/srof_back.sv
// ----------------------------------------------------------------------------
// srof_back
// Session state: counts, best estimate, end conditions and config registers.
// ----------------------------------------------------------------------------
module srof_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srof_pkg::cfg_wr_t   cfg_i,
  input  srof_pkg::work_t     work_i,
  input  logic                work_empty_i,
  output logic                work_pop_o,
  output srof_pkg::out_item_t res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);
  import srof_pkg::*;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'b01,
    BK_COMMIT = 2'b10
  } bk_state_e;

  bk_state_e   state_q, state_d;
  logic        go;

  logic [7:0]  max_q;
  logic [39:0] goal_q;
  logic [47:0] init_err_q;

  logic [7:0]  acc_q, acc_d;
  logic [8:0]  rej_q, rej_d;
  logic [63:0] boff_q, boff_d, berr_q, berr_d;
  logic        over_q, over_d, alarm_q, alarm_d;

  // evaluation registers
  work_t       wk_q;
  logic [63:0] a_q;
  logic [64:0] b_q;
  logic        lt_q, sgoal_q, bgoal_q;
  logic [64:0] d1, d2;

  logic [7:0]  acc_inc;
  logic [8:0]  rej_inc;
  logic        bad, goal_hit;

  assign go         = (state_q == BK_IDLE) && !work_empty_i && !res_full_i;
  assign work_pop_o = go;
  assign res_push_o = (state_q == BK_COMMIT);

  assign d1 = {work_i.sample_offset[63], work_i.sample_offset} - {boff_q[63], boff_q};
  assign d2 = {boff_q[63], boff_q} - {work_i.sample_offset[63], work_i.sample_offset};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (go) state_d = BK_COMMIT;
      BK_COMMIT: state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  assign acc_inc  = acc_q + 1'b1;
  assign rej_inc  = rej_q + 1'b1;
  assign bad      = (acc_q != '0) && !b_q[64] && (a_q > b_q[63:0]);
  assign goal_hit = lt_q ? sgoal_q : bgoal_q;

  always_comb begin
    acc_d   = acc_q;
    rej_d   = rej_q;
    boff_d  = boff_q;
    berr_d  = berr_q;
    over_d  = over_q;
    alarm_d = alarm_q;
    res_o   = '0;
    res_o.verdict       = VD_IGNORED;
    res_o.reject_reason = RS_NONE;
    if (wk_q.action == ACT_START) begin
      acc_d  = '0;
      rej_d  = '0;
      boff_d = '0;
      berr_d = {16'd0, init_err_q};
      over_d = 1'b0;
      res_o.verdict = VD_STARTED;
    end else if (wk_q.action != ACT_NONE && !over_q) begin
      if (wk_q.reason != RS_NONE) begin
        rej_d = rej_inc;
        res_o.reject_reason = wk_q.reason;
        if (rej_inc > {1'b0, max_q}) begin
          res_o.verdict = VD_FAIL_REJECTS;
          over_d = 1'b1;
        end else begin
          res_o.verdict = VD_REJECTED;
        end
      end else begin
        acc_d = acc_inc;
        res_o.sample_offset = wk_q.sample_offset;
        res_o.sample_error  = wk_q.sample_error;
        // flag the alarm leap indicator once per reset
        if (wk_q.leap_alarm && !alarm_q) begin
          alarm_d = 1'b1;
          res_o.alarm_first = 1'b1;
        end
        if (lt_q) begin
          boff_d = wk_q.sample_offset;
          berr_d = wk_q.sample_error;
        end
        if (bad) begin
          res_o.verdict = VD_FAIL_INCONS;
          over_d = 1'b1;
        end else if (goal_hit) begin
          res_o.verdict = VD_GOAL_MET;
          over_d = 1'b1;
        end else if (acc_inc >= max_q) begin
          res_o.verdict = VD_LIMIT;
          over_d = 1'b1;
        end else begin
          res_o.verdict = VD_ACCEPTED;
        end
      end
    end
    res_o.best_offset_out = boff_d;
    res_o.best_error_out  = berr_d;
    res_o.accepted_out    = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      max_q      <= MAX_QUERIES_RST;
      goal_q     <= ERROR_GOAL_RST;
      init_err_q <= INITIAL_ERROR_RST;
      acc_q      <= '0;
      rej_q      <= '0;
      boff_q     <= '0;
      berr_q     <= {16'd0, INITIAL_ERROR_RST};
      over_q     <= 1'b1;
      alarm_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_MAX_QUERIES:   max_q      <= cfg_i.data[7:0];
          CFG_ERROR_GOAL:    goal_q     <= cfg_i.data[39:0];
          CFG_INITIAL_ERROR: init_err_q <= cfg_i.data;
          default:           ;
        endcase
      end
      if (state_q == BK_COMMIT) begin
        acc_q   <= acc_d;
        rej_q   <= rej_d;
        boff_q  <= boff_d;
        berr_q  <= berr_d;
        over_q  <= over_d;
        alarm_q <= alarm_d;
      end
    end
  end

  // evaluate against the current best while the state is stable
  always_ff @(posedge clk_i) begin
    if (go) begin
      wk_q    <= work_i;
      a_q     <= d1[64] ? d2[63:0] : d1[63:0];
      b_q     <= {1'b0, work_i.sample_error} + {1'b0, berr_q};
      lt_q    <= work_i.sample_error < berr_q;
      sgoal_q <= work_i.sample_error <= {24'd0, goal_q};
      bgoal_q <= berr_q <= {24'd0, goal_q};
    end
  end

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_COMMIT && wk_q.action != ACT_START) |=> (berr_q <= $past(berr_q)))
    else $error("best error grew inside a session");

  a_end_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.verdict == VD_FAIL_REJECTS || res_o.verdict == VD_FAIL_INCONS ||
                    res_o.verdict == VD_GOAL_MET || res_o.verdict == VD_LIMIT))
    |=> over_q)
    else $error("session end verdict without session over");

  a_room_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_COMMIT) |-> !res_full_i)
    else $error("result queue full at commit");

endmodule
